// ----- rtl/core/rbc_pkg.sv -----
package rbc_pkg;

   // field widths
   localparam int PIX_W   = 8;
   localparam int LEVEL_W = 9;
   localparam int LANES   = 3;

   // gain format: unsigned, GAIN_INT_BITS integer bits above the fraction
   localparam int GAIN_FRAC_BITS_DEFAULT = 16;
   localparam int GAIN_INT_BITS          = 8;

   // 259 * (c + 255) stays below 2^18, 255 * (259 - c) below 2^17
   localparam int NUMER_BASE_W = 18;
   localparam int DENOM_W      = 17;
   localparam int GAIN_NUM_K   = 259;
   localparam int GAIN_DEN_K   = 255;
   localparam int DENOM_OFFSET = 259;
   localparam int LEVEL_OFFSET = 255;

   // channel arithmetic constants
   localparam int CHAN_MID = 128;
   localparam int CHAN_MAX = 255;

   // configuration register map
   localparam int CSR_INDEX_W = 2;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_BRIGHTNESS = 2'd0;
   localparam csr_index_type REG_CONTRAST   = 2'd1;

   // contrast pattern that saturates to the most negative legal level
   localparam logic [LEVEL_W-1:0] LEVEL_PATTERN_MIN = 9'h100;
   localparam logic [LEVEL_W-1:0] LEVEL_LEGAL_MIN   = 9'h101;

   typedef logic [PIX_W-1:0] pix_type;

endpackage

// ----- rtl/core/rbc_gain_div.sv -----
module rbc_gain_div #(
   parameter int GAIN_FRAC_BITS = rbc_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              start,
   input  logic signed [rbc_pkg::LEVEL_W-1:0]                level,
   output logic                                              busy,
   output logic [GAIN_FRAC_BITS+rbc_pkg::GAIN_INT_BITS-1:0] gain
);

   localparam int GAIN_W  = GAIN_FRAC_BITS + rbc_pkg::GAIN_INT_BITS;
   localparam int NUM_W   = rbc_pkg::NUMER_BASE_W + GAIN_FRAC_BITS;
   localparam int DEN_W   = rbc_pkg::DENOM_W;
   localparam int CNT_W   = $clog2(NUM_W + 1);
   localparam int LW      = rbc_pkg::LEVEL_W;

   logic [LW-1:0]         level_sat;
   logic signed [LW:0]    plus_wide;
   logic signed [LW+1:0]  minus_wide;
   logic [LW-1:0]         plus;
   logic [LW:0]           minus;
   logic [rbc_pkg::NUMER_BASE_W-1:0] num_base;
   logic [DEN_W-1:0]      den_start;

   logic [NUM_W-1:0]      num_ff, num_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      den_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  busy_ff;
   logic [GAIN_W-1:0]     gain_ff;

   logic [DEN_W:0]        trial;
   logic [DEN_W:0]        trial_sub;
   logic                  trial_ge;

   // operand set-up: saturate the level, then the two constant products
   assign level_sat  = (level == rbc_pkg::LEVEL_PATTERN_MIN) ?
                       rbc_pkg::LEVEL_LEGAL_MIN : level;
   assign plus_wide  = $signed({level_sat[LW-1], level_sat}) +
                       (LW+1)'(rbc_pkg::LEVEL_OFFSET);
   assign minus_wide = (LW+2)'(rbc_pkg::DENOM_OFFSET) -
                       $signed({{2{level_sat[LW-1]}}, level_sat});
   assign plus       = plus_wide[LW-1:0];
   assign minus      = minus_wide[LW:0];
   assign num_base   = rbc_pkg::NUMER_BASE_W'(plus) *
                       rbc_pkg::NUMER_BASE_W'(rbc_pkg::GAIN_NUM_K);
   assign den_start  = DEN_W'(DEN_W'(minus) * DEN_W'(rbc_pkg::GAIN_DEN_K));

   // one restoring step per cycle, quotient bits shift into the numerator
   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge  = (trial >= {1'b0, den_ff});
   assign trial_sub = trial - {1'b0, den_ff};
   assign rem_in    = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
   assign num_in    = {num_ff[NUM_W-2:0], trial_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
         gain_ff  <= GAIN_W'(1) << GAIN_FRAC_BITS;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CNT_W'(NUM_W);
         num_ff   <= {num_base, {GAIN_FRAC_BITS{1'b0}}};
         rem_ff   <= '0;
         den_ff   <= den_start;
      end else if (busy_ff) begin
         num_ff   <= num_in;
         rem_ff   <= rem_in;
         count_ff <= count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            gain_ff <= num_in[GAIN_W-1:0];
         end
      end
   end

   assign busy = busy_ff;
   assign gain = gain_ff;

endmodule

// ----- rtl/core/rgb_brightness_contrast.sv -----
// rgb_brightness_contrast
// one rgb888 pixel in, one adjusted pixel out. each channel gets the signed
// brightness offset added and clamped to 0..255, then is scaled around 128 by
// the contrast gain (unsigned fixed point, GAIN_FRAC_BITS fraction bits),
// floored and clamped again.
// req_ channel: pixel transaction in, taken when req_valid is high and
//   req_stall is low. rsp_ channel: result transaction out, same rule.
// csr_ channel: index 0 brightness, 1 contrast, others ignored; written when
//   csr_valid and csr_ready are high.
// throughput: one pixel per cycle when not stalled. the input transaction
//   loads the input register, then the result register loads from it and
//   rsp_valid rises.
// a contrast write starts the gain divider, a restoring divider that retires
//   one quotient bit per cycle. while it runs, req_stall is high and
//   csr_ready is low.
// reset: brightness cleared, gain set to unity, pipeline emptied. there
//   is no clearing pass.
// rsp_stall holds the result register; the input register still takes one
//   more pixel, after which req_stall follows rsp_stall.
module rgb_brightness_contrast #(
   parameter int GAIN_FRAC_BITS = rbc_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel in
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rbc_pkg::PIX_W-1:0]          req_pixel_red,
   input  logic [rbc_pkg::PIX_W-1:0]          req_pixel_green,
   input  logic [rbc_pkg::PIX_W-1:0]          req_pixel_blue,
   // pixel out
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rbc_pkg::PIX_W-1:0]          rsp_out_red,
   output logic [rbc_pkg::PIX_W-1:0]          rsp_out_green,
   output logic [rbc_pkg::PIX_W-1:0]          rsp_out_blue,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbc_pkg::LEVEL_W-1:0]        csr_data
);

   localparam int GAIN_W = GAIN_FRAC_BITS + rbc_pkg::GAIN_INT_BITS;
   localparam int PW     = rbc_pkg::PIX_W;
   localparam int LW     = rbc_pkg::LEVEL_W;
   // signed gain times signed (v - 128)
   localparam int PROD_W = GAIN_W + 1 + LW;
   // floored quotient after dropping the fraction bits
   localparam int Q_W    = PROD_W - GAIN_FRAC_BITS;
   localparam int NL     = rbc_pkg::LANES;

   // configuration
   logic signed [LW-1:0]      brightness_ff;
   logic                      csr_write;
   logic                      gain_start;
   logic                      gain_busy;
   logic [GAIN_W-1:0]         gain;

   // pipeline control
   logic                      req_take;
   logic                      out_en;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rbc_pkg::pix_type [NL-1:0] s1_pix_ff;
   rbc_pkg::pix_type [NL-1:0] rsp_pix_ff;

   // per-lane datapath
   logic signed [LW:0]        bright_sum [NL];
   logic [PW-1:0]             bright_clamp [NL];
   logic signed [LW-1:0]      centred [NL];
   logic signed [GAIN_W:0]    gain_s;
   logic signed [PROD_W-1:0]  prod [NL];
   logic signed [Q_W-1:0]     quot [NL];
   logic signed [Q_W:0]       shifted [NL];
   rbc_pkg::pix_type [NL-1:0] lane_out;

   // ---------------------------------------------------------------------
   // register writes; a contrast write kicks the gain divider
   // ---------------------------------------------------------------------
   assign csr_ready  = !gain_busy;
   assign csr_write  = csr_valid && csr_ready;
   assign gain_start = csr_write && (csr_index == rbc_pkg::REG_CONTRAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            rbc_pkg::REG_BRIGHTNESS: brightness_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rbc_gain_div #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_gain_div (
      .clock (clock),
      .reset (reset),
      .start (gain_start),
      .level (csr_data),
      .busy  (gain_busy),
      .gain  (gain)
   );

   // ---------------------------------------------------------------------
   // two-register pipeline: input register, result register
   // ---------------------------------------------------------------------
   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = gain_busy || (s1_valid_ff && !out_en);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (out_en) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = out_en ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pix_ff <= {req_pixel_blue, req_pixel_green, req_pixel_red};
      end
      if (out_en && s1_valid_ff) begin
         rsp_pix_ff <= lane_out;
      end
   end

   // ---------------------------------------------------------------------
   // per channel: brightness add and clamp, contrast scale around mid grey,
   // floor by arithmetic shift, re-centre and clamp
   // ---------------------------------------------------------------------
   assign gain_s = $signed({1'b0, gain});

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         bright_sum[i] = $signed({2'b00, s1_pix_ff[i]}) +
                         $signed({brightness_ff[LW-1], brightness_ff});
         if (bright_sum[i] < 0) begin
            bright_clamp[i] = '0;
         end else if (bright_sum[i] > (LW+1)'(rbc_pkg::CHAN_MAX)) begin
            bright_clamp[i] = PW'(rbc_pkg::CHAN_MAX);
         end else begin
            bright_clamp[i] = bright_sum[i][PW-1:0];
         end
         centred[i] = $signed({1'b0, bright_clamp[i]}) - LW'(rbc_pkg::CHAN_MID);
         prod[i]    = gain_s * centred[i];
         quot[i]    = prod[i][PROD_W-1:GAIN_FRAC_BITS];
         shifted[i] = $signed({quot[i][Q_W-1], quot[i]}) +
                      (Q_W+1)'(rbc_pkg::CHAN_MID);
         if (shifted[i] < 0) begin
            lane_out[i] = '0;
         end else if (shifted[i] > (Q_W+1)'(rbc_pkg::CHAN_MAX)) begin
            lane_out[i] = PW'(rbc_pkg::CHAN_MAX);
         end else begin
            lane_out[i] = shifted[i][PW-1:0];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff[0];
   assign rsp_out_green = rsp_pix_ff[1];
   assign rsp_out_blue  = rsp_pix_ff[2];

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // a contrast write always leaves the divider running
   assert property (@(posedge clock) disable iff (reset)
      gain_start |=> gain_busy)
      else $error("contrast write did not start the gain divider");

   // a held input register keeps its pixel while the result side is stalled
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_en) |=> (s1_valid_ff && $stable(s1_pix_ff)))
      else $error("input register lost a pixel under stall");

   // a result only appears after the input register held a pixel
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result raised with no pixel in flight");

   // no pixel enters while the gain is being recomputed
   assert property (@(posedge clock) disable iff (reset)
      gain_busy |=> ($past(s1_valid_in) == s1_valid_ff) && !(req_take && gain_busy))
      else $error("pixel taken during gain update");

endmodule
